// ===== rtl/itoa_pkg.sv =====
// Shared constants, types and helper functions for the integer-to-decimal converter.
`default_nettype none

package itoa_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    // magnitude bits folded into the BCD register per cycle
    localparam int STEP_BITS = 4;

    localparam logic [5:0] CHAR_MINUS = 6'd45;
    localparam logic [5:0] CHAR_ZERO  = 6'd48;

    // decimal digits needed for the largest magnitude, 2^(w-1)
    function automatic int dec_digits(input int w);
        longint unsigned v;
        int n;
        v = longint'(1) << (w - 1);
        n = 0;
        do begin
            n = n + 1;
            v = v / 10;
        end while (v != 0);
        return n;
    endfunction

    function automatic int conv_steps(input int w);
        return (w + STEP_BITS - 1) / STEP_BITS;
    endfunction

    typedef struct packed {
        logic load;
        logic step;
        logic prep;
        logic next_digit;
        logic sel_sign;
    } dp_cmd_t;

    typedef struct packed {
        logic conv_done;
        logic negative;
        logic idx_zero;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/itoa_datapath.sv =====
// Datapath: sign/magnitude, shift-add-3 BCD conversion, digit index and character select.
`default_nettype none

module itoa_datapath #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire  signed [VALUE_WIDTH-1:0] value,
    input  itoa_pkg::dp_cmd_t            cmd,
    output itoa_pkg::dp_status_t         status,
    output logic [5:0]                   ascii_char
);

    localparam int NDIG  = itoa_pkg::dec_digits(VALUE_WIDTH);
    localparam int STEPS = itoa_pkg::conv_steps(VALUE_WIDTH);
    localparam int SB    = itoa_pkg::STEP_BITS;
    localparam int PAD_W = STEPS * SB;
    localparam int BCD_W = NDIG * 4;
    localparam int IDX_W = $clog2(NDIG);
    localparam int CNT_W = $clog2(STEPS);

    logic [PAD_W-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic [VALUE_WIDTH-1:0] mag_in;
    logic [BCD_W-1:0]       bcd_step;
    logic [PAD_W-1:0]       mag_step;
    logic [IDX_W-1:0]       msd_idx;
    logic [3:0]             cur_digit;

    // two's complement negate; the most negative value comes out as its exact magnitude
    assign mag_in = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

    // shift-add-3 over STEP_BITS bits per cycle
    always_comb
    begin
        logic [BCD_W-1:0] b;
        logic [PAD_W-1:0] m;
        b = bcd_reg;
        m = mag_reg;
        for (int s = 0; s < SB; s++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (b[d*4 +: 4] >= 4'd5)
                    b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
            end
            b = {b[BCD_W-2:0], m[PAD_W-1]};
            m = {m[PAD_W-2:0], 1'b0};
        end
        bcd_step = b;
        mag_step = m;
    end

    // most significant nonzero digit, or digit 0 for zero
    always_comb
    begin
        msd_idx = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_reg[i*4 +: 4] != 4'd0)
                msd_idx = IDX_W'(i);
        end
    end

    always_comb
    begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (cmd.load) begin
            mag_next = PAD_W'(mag_in);
            bcd_next = '0;
            neg_next = value[VALUE_WIDTH-1];
            cnt_next = '0;
        end else if (cmd.step) begin
            mag_next = mag_step;
            bcd_next = bcd_step;
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.prep)
            idx_next = msd_idx;
        else if (cmd.next_digit)
            idx_next = idx_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
            idx_reg <= '0;
            neg_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            neg_reg <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign cur_digit = bcd_reg[idx_reg*4 +: 4];
    assign ascii_char = cmd.sel_sign ? itoa_pkg::CHAR_MINUS
                                     : ({2'b00, cur_digit} + itoa_pkg::CHAR_ZERO);

    assign status.conv_done = (cnt_reg == CNT_W'(STEPS - 1));
    assign status.negative  = neg_reg;
    assign status.idx_zero  = (idx_reg == '0);

endmodule

`default_nettype wire

// ===== rtl/itoa_ctrl.sv =====
// Controller: sequences accept, conversion steps, digit search and character beats.
`default_nettype none

module itoa_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   value_valid,
    output logic                  value_ready,
    output logic                  char_valid,
    input  wire                   char_ready,
    output logic                  last,
    input  itoa_pkg::dp_status_t  status,
    output itoa_pkg::dp_cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_PREP  = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_DIGIT = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        value_ready = 1'b0;
        char_valid  = 1'b0;
        last        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                value_ready = 1'b1;
                if (value_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.step = 1'b1;
                if (status.conv_done)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = status.negative ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                cmd.sel_sign = 1'b1;
                char_valid   = 1'b1;
                if (char_ready)
                    state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                char_valid = 1'b1;
                last       = status.idx_zero;
                if (char_ready) begin
                    if (status.idx_zero)
                        state_next = ST_IDLE;
                    else
                        cmd.next_digit = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Signed integer to decimal ASCII text converter, one character per output beat.
//
// Input channel value/value_valid/value_ready takes one signed integer per beat.
// Output channel ascii_char/last/char_valid/char_ready gives its decimal text,
// most significant character first: an optional '-', then the digits without
// leading zeros ('0' alone for zero). last marks the final digit.
// Per value: accept, conversion in the shift-add-3 BCD unit (4 bits per cycle,
// no stall there), leading-digit search, then one character per output beat
// (1 to 11 characters at VALUE_WIDTH = 32). One value is in flight at a time
// and value_ready is high only while idle.
// Output payload is held from registers: a stall on char_ready freezes the
// current character until it is taken.
// Reset (rst_n, asynchronous, active low) returns the controller to idle; no
// state carries from one value to the next.
`default_nettype none

module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire  signed [VALUE_WIDTH-1:0] value,
    input  wire                           value_valid,
    output logic                          value_ready,
    output logic [5:0]                    ascii_char,
    output logic                          last,
    output logic                          char_valid,
    input  wire                           char_ready
);

    itoa_pkg::dp_cmd_t    cmd;
    itoa_pkg::dp_status_t status;

    itoa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .last        (last),
        .status      (status),
        .cmd         (cmd)
    );

    itoa_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .cmd        (cmd),
        .status     (status),
        .ascii_char (ascii_char)
    );

endmodule

`default_nettype wire

// ===== tb/tb_signed_int_to_decimal_ascii.sv =====
// Testbench for the signed integer to decimal ASCII converter.
`default_nettype none

module tb_signed_int_to_decimal_ascii;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W           = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic [5:0] ch;
        logic       lst;
    } char_beat_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic signed [W-1:0] value;
    logic                value_valid;
    wire                 value_ready;
    wire [5:0]           ascii_char;
    wire                 last;
    wire                 char_valid;
    logic                char_ready;

    char_beat_t expected_text[$];
    int         error_count    = 0;
    int         values_sent    = 0;
    int         negatives_sent = 0;
    int         chars_checked  = 0;
    int         cycle_count    = 0;
    bit         idle_en        = 1'b1;
    int         hold_request   = 0;

    signed_int_to_decimal_ascii #(.VALUE_WIDTH(W)) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .ascii_char  (ascii_char),
        .last        (last),
        .char_valid  (char_valid),
        .char_ready  (char_ready)
    );

    always #2 clk = ~clk;

    // Expected characters for one value: optional '-', digits MSB first, last on final digit
    function automatic void predict_decimal_text(input logic signed [W-1:0] v);
        logic [63:0] mag;
        logic [3:0]  digs [0:19];
        int          nd;
        bit          neg;
        char_beat_t  cb;
        neg = v[W-1];
        // magnitude in 64 bits so the most negative value stays exact
        mag = neg ? ((64'd1 << W) - {{(64-W){1'b0}}, v}) : {{(64-W){1'b0}}, v};
        nd = 0;
        do begin
            digs[nd] = 4'(mag % 64'd10);
            mag = mag / 64'd10;
            nd++;
        end while (mag != 0);
        if (neg) begin
            cb.ch = itoa_pkg::CHAR_MINUS;
            cb.lst = 1'b0;
            expected_text.push_back(cb);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            cb.ch = itoa_pkg::CHAR_ZERO + 6'(digs[i]);
            cb.lst = (i == 0);
            expected_text.push_back(cb);
        end
    endfunction

    task automatic send_value(input logic signed [W-1:0] v);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            value_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        value <= v;
        value_valid <= 1'b1;
        do @(posedge clk); while (!value_ready);
        predict_decimal_text(v);
        values_sent++;
        if (v < 0)
            negatives_sent++;
    endtask

    // Sender stops and waits until every expected character has come out
    task automatic wait_text_drained();
        value_valid <= 1'b0;
        do @(posedge clk); while (expected_text.size() != 0);
    endtask

    function automatic logic signed [W-1:0] pick_value();
        int unsigned    sel;
        int unsigned    k;
        longint         lim;
        logic [W-1:0]   r;
        sel = $urandom_range(0, 9);
        r = $urandom;
        if (sel < 5) begin
            // digit count spread evenly rather than skewed to 10 digits
            k = $urandom_range(1, 9);
            lim = 1;
            repeat (k) lim = lim * 10;
            r = W'(longint'($urandom) % lim);
            if ($urandom_range(0, 1))
                r = -r;
        end else if (sel == 8) begin
            if ($urandom_range(0, 1))
                r = 32'h7FFF_FFFF - W'($urandom_range(0, 20));
            else
                r = 32'h8000_0000 + W'($urandom_range(0, 20));
        end else if (sel == 9) begin
            k = $urandom_range(1, 9);
            lim = 1;
            repeat (k) lim = lim * 10;
            r = W'(lim + $signed($urandom_range(0, 2)) - 1);
            if ($urandom_range(0, 1))
                r = -r;
        end
        return r;
    endfunction

    task automatic test_directed_values();
        logic signed [W-1:0] list [$];
        list = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -67890,
                 999999999, 1000000000, -1000000000, 2147483647, -2147483647,
                 32'sh8000_0000, 1234567890, -1234567890, 7, 1000000001};
        foreach (list[i])
            send_value(list[i]);
        wait_text_drained();
    endtask

    // Receiver holds off while the sender keeps offering; input must stall
    task automatic test_output_backpressure();
        idle_en = 1'b0;
        hold_request = LONG_HOLD;
        for (int i = 0; i < 5; i++)
            send_value(pick_value());
        wait_text_drained();
        idle_en = 1'b1;
    endtask

    task automatic test_random_with_idles();
        for (int i = 0; i < 85; i++) begin
            send_value(pick_value());
            if (i == 40)
                wait_text_drained();
        end
        wait_text_drained();
    endtask

    task automatic test_random_full_rate();
        idle_en = 1'b0;
        for (int i = 0; i < 40; i++)
            send_value(pick_value());
        wait_text_drained();
    endtask

    // Receiver: random stall bursts, or one long hold when requested
    initial begin
        int n;
        char_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
                char_ready <= 1'b0;
                repeat (n) @(posedge clk);
                char_ready <= 1'b1;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                char_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                char_ready <= 1'b1;
            end else begin
                char_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        char_beat_t want;
        if (rst_n && char_valid && char_ready) begin
            chars_checked++;
            if (expected_text.size() == 0) begin
                error_count++;
                $display("%0t: unexpected beat, expected none, actual char %0d last %0b",
                         $time, ascii_char, last);
            end else begin
                want = expected_text.pop_front();
                if (ascii_char !== want.ch) begin
                    error_count++;
                    $display("%0t: ascii_char mismatch, expected %0d, actual %0d",
                             $time, want.ch, ascii_char);
                end
                if (last !== want.lst) begin
                    error_count++;
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $time, want.lst, last);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d characters still expected", $time,
                     expected_text.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        rst_n <= 1'b0;
        value <= '0;
        value_valid <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_values();
        test_output_backpressure();
        test_random_with_idles();
        test_random_full_rate();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Converted %0d values (%0d negative), %0d characters checked,",
                 values_sent, negatives_sent, chars_checked);
        $display("including both extremes, zero, a long output hold and idle-free streaming.");
        if (error_count == 0 && expected_text.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/itoa_pkg.sv
rtl/itoa_datapath.sv
rtl/itoa_ctrl.sv
rtl/signed_int_to_decimal_ascii.sv
tb/tb_signed_int_to_decimal_ascii.sv
